// File: rtl/rfc_pkg.sv
// Shared types, constants and the power-of-ten selection for the reciprocal
// frequency counter. No dependencies; imported by every other rtl file.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // Reference timebase in Hz and the dividend of the interval frequency view
    localparam logic [31:0] REF_CLOCK_HZ  = 32'd4194304;
    localparam logic [31:0] FREQ_DIVIDEND = 32'(64'(REF_CLOCK_HZ) * 64'd1000);

    localparam logic [31:0] OVERFLOW_STEP   = 32'h0001_0000;
    localparam logic [15:0] GATE_TICKS_RST  = 16'd256;
    localparam logic [7:0]  POINT_MASK_FREQ = 8'd8;
    localparam logic [7:0]  POINT_MASK_NONE = 8'd0;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

    // Largest count that keeps count * 10^(i+1) inside 32 bits
    localparam logic [31:0] MUL_LIMIT [0:8] = '{
        32'd429496729, 32'd42949672, 32'd4294967, 32'd429496, 32'd42949,
        32'd4294, 32'd429, 32'd42, 32'd4
    };
    localparam logic [31:0] POW_TEN [0:9] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_OVERFLOW = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_EDGE     = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_INTERVAL_MODE = 2'd0,
        CFG_SHOW_TIME     = 2'd1,
        CFG_GATE_TICKS    = 2'd2
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    // Serial arithmetic unit interface
    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_sts_t;

    // First table entry whose limit does not exceed the count; 10^9 if none
    function automatic logic [31:0] pow_select(input logic [31:0] m);
        logic [31:0] p;
        p = POW_TEN[9];
        for (int i = 8; i >= 0; i--)
        begin
            if (MUL_LIMIT[i] <= m)
            begin
                p = POW_TEN[i];
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rfc_serial_arith.sv
// Bit-serial 32-bit multiplier (modulo 2^32) and restoring divider sharing one
// datapath. Depends on rfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfc_serial_arith (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rfc_pkg::arith_cmd_t cmd,
    input  wire logic [31:0]        a,
    input  wire logic [31:0]        b,
    output rfc_pkg::arith_sts_t     sts,
    output logic [31:0]             result
);
    import rfc_pkg::*;

    // hi: product accumulator / partial remainder
    // lo: multiplier / dividend shifting into quotient
    // b : multiplicand / divisor
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] b_reg, b_next;
    arith_op_t   op_reg, op_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [32:0] shifted;
    logic [32:0] diff;

    // One multiplier bit or one quotient bit per cycle
    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {hi_reg, lo_reg[31]};
        diff      = shifted - {1'b0, b_reg};

        if (cmd.start)
        begin
            op_next   = cmd.op;
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            hi_next   = 32'd0;
            unique case (cmd.op)
                ARITH_MUL:
                begin
                    b_next  = a;
                    lo_next = b;
                end
                ARITH_DIV:
                begin
                    lo_next = a;
                    b_next  = b;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ARITH_MUL:
                begin
                    if (lo_reg[0])
                    begin
                        hi_next = hi_reg + b_reg;
                    end
                    b_next  = {b_reg[30:0], 1'b0};
                    lo_next = {1'b0, lo_reg[31:1]};
                end
                ARITH_DIV:
                begin
                    if (!diff[32])
                    begin
                        hi_next = diff[31:0];
                        lo_next = {lo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        hi_next = shifted[31:0];
                        lo_next = {lo_reg[30:0], 1'b0};
                    end
                end
            endcase
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
        op_reg <= op_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = (op_reg == ARITH_MUL) ? hi_reg : lo_reg;

    // Checks
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("arith start while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("arith done while still busy");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(cmd.start))
        else $error("arith busy without start");

endmodule

`default_nettype wire

// File: rtl/reciprocal_frequency_counter_top.sv
// Top level of the reciprocal frequency counter: event handling, gate timing,
// result sequencing and output register. Depends on rfc_pkg, rfc_serial_arith.
`timescale 1ns / 1ps
`default_nettype none

// Reciprocal frequency counter core. Input words report timer overflows, gate
// ticks and input edge captures; a closing gate tick yields one result word in
// frequency mode, or in interval mode if a measurement is ready. Other words
// are taken at one per cycle while the sequencer is idle. A result word stalls
// the input until the sequencer is idle again: frequency mode, or a zero
// count in the interval frequency view, goes straight to output; that view
// otherwise runs one 32-step serial division, the time view a 32-step serial
// multiply then the division, both on the single serial unit rfc_serial_arith.
// The output register holds a finished word while further words are taken.
module reciprocal_frequency_counter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] capture_value,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value,
    output logic [7:0]       point_mask,
    output logic             divide_fault
);
    import rfc_pkg::*;

    // Configuration
    logic        interval_mode_reg, interval_mode_next;
    logic        show_time_reg, show_time_next;
    logic [15:0] gate_ticks_reg, gate_ticks_next;

    // Measurement state
    logic [31:0] running_count_reg, running_count_next;
    logic [15:0] last_capture_reg, last_capture_next;
    logic [31:0] measurement_reg, measurement_next;
    logic        meas_ready_reg, meas_ready_next;
    logic [15:0] tick_count_reg, tick_count_next;

    // Sequencer and result
    state_t      state_reg, state_next;
    logic [31:0] pend_val_reg;
    logic [7:0]  pend_mask_reg;
    logic        pend_fault_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg;
    logic [7:0]  point_mask_reg;
    logic        divide_fault_reg;

    logic        in_accept;
    logic        emit;
    logic [31:0] emit_meas;
    logic [15:0] tick_limit;
    logic [31:0] close_value;
    logic        out_load;

    arith_cmd_t  arith_cmd;
    arith_sts_t  arith_sts;
    logic [31:0] arith_a;
    logic [31:0] arith_b;
    logic [31:0] arith_result;

    assign in_accept = in_valid && !in_stall;

    // Event handling and configuration writes
    always_comb
    begin
        interval_mode_next = interval_mode_reg;
        show_time_next     = show_time_reg;
        gate_ticks_next    = gate_ticks_reg;
        running_count_next = running_count_reg;
        last_capture_next  = last_capture_reg;
        measurement_next   = measurement_reg;
        meas_ready_next    = meas_ready_reg;
        tick_count_next    = tick_count_reg;
        emit               = 1'b0;
        emit_meas          = measurement_reg;
        tick_limit         = gate_ticks_reg - 16'd1;
        close_value        = running_count_reg + {16'd0, capture_value}
                             - {16'd0, last_capture_reg};

        if (in_accept)
        begin
            case (kind)
                KIND_OVERFLOW:
                begin
                    running_count_next = running_count_reg + OVERFLOW_STEP;
                end
                KIND_EDGE:
                begin
                    if (interval_mode_reg)
                    begin
                        measurement_next   = close_value;
                        running_count_next = 32'd0;
                        last_capture_next  = capture_value;
                        meas_ready_next    = 1'b1;
                    end
                end
                KIND_TICK:
                begin
                    if (tick_count_reg < tick_limit)
                    begin
                        tick_count_next = tick_count_reg + 16'd1;
                    end
                    else
                    begin
                        tick_count_next = 16'd0;
                        if (!interval_mode_reg)
                        begin
                            measurement_next   = close_value;
                            running_count_next = 32'd0;
                            last_capture_next  = capture_value;
                            emit               = 1'b1;
                            emit_meas          = close_value;
                        end
                        else
                        begin
                            emit = meas_ready_reg;
                        end
                        meas_ready_next = !interval_mode_reg && !emit;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_INTERVAL_MODE:
                begin
                    interval_mode_next = cfg_data[0];
                    running_count_next = 32'd0;
                    last_capture_next  = 16'd0;
                    measurement_next   = 32'd0;
                    meas_ready_next    = 1'b0;
                end
                CFG_SHOW_TIME:
                begin
                    show_time_next     = cfg_data[0];
                    running_count_next = 32'd0;
                    last_capture_next  = 16'd0;
                    measurement_next   = 32'd0;
                    meas_ready_next    = 1'b0;
                end
                CFG_GATE_TICKS:
                begin
                    gate_ticks_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (emit)
                begin
                    priority if (!interval_mode_reg)
                        state_next = S_OUT;
                    else if (show_time_reg)
                        state_next = S_MUL;
                    else if (emit_meas == 32'd0)
                        state_next = S_OUT;
                    else
                        state_next = S_DIV;
                end
            end
            S_MUL:
            begin
                if (arith_sts.done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (arith_sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs: stall, arithmetic commands, output load
    always_comb
    begin
        in_stall        = 1'b1;
        arith_cmd.start = 1'b0;
        arith_cmd.op    = ARITH_DIV;
        arith_a         = FREQ_DIVIDEND;
        arith_b         = emit_meas;
        out_load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (emit && interval_mode_reg)
                begin
                    if (show_time_reg)
                    begin
                        arith_cmd.start = 1'b1;
                        arith_cmd.op    = ARITH_MUL;
                        arith_a         = emit_meas;
                        arith_b         = pow_select(emit_meas);
                    end
                    else if (emit_meas != 32'd0)
                    begin
                        arith_cmd.start = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (arith_sts.done)
                begin
                    arith_cmd.start = 1'b1;
                    arith_a         = arith_result;
                    arith_b         = REF_CLOCK_HZ;
                end
            end
            S_DIV:
            begin
            end
            S_OUT:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    rfc_serial_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (arith_cmd),
        .a      (arith_a),
        .b      (arith_b),
        .sts    (arith_sts),
        .result (arith_result)
    );

    // Control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_mode_reg <= 1'b0;
            show_time_reg     <= 1'b0;
            gate_ticks_reg    <= GATE_TICKS_RST;
            running_count_reg <= 32'd0;
            last_capture_reg  <= 16'd0;
            measurement_reg   <= 32'd0;
            meas_ready_reg    <= 1'b0;
            tick_count_reg    <= 16'd0;
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            interval_mode_reg <= interval_mode_next;
            show_time_reg     <= show_time_next;
            gate_ticks_reg    <= gate_ticks_next;
            running_count_reg <= running_count_next;
            last_capture_reg  <= last_capture_next;
            measurement_reg   <= measurement_next;
            meas_ready_reg    <= meas_ready_next;
            tick_count_reg    <= tick_count_next;
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Pending result and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && emit)
        begin
            pend_val_reg   <= interval_mode_reg ? ALL_ONES : emit_meas;
            pend_mask_reg  <= (interval_mode_reg && !show_time_reg) ?
                              POINT_MASK_FREQ : POINT_MASK_NONE;
            pend_fault_reg <= interval_mode_reg && !show_time_reg
                              && (emit_meas == 32'd0);
        end
        else if (state_reg == S_DIV && arith_sts.done)
        begin
            pend_val_reg <= arith_result;
        end
        if (out_load)
        begin
            value_reg        <= pend_val_reg;
            point_mask_reg   <= pend_mask_reg;
            divide_fault_reg <= pend_fault_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign point_mask   = point_mask_reg;
    assign divide_fault = divide_fault_reg;

    // Checks
    a_arith_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_DIV)
            |-> (arith_sts.busy || arith_sts.done))
        else $error("waiting on arithmetic unit that is not running");

    a_fault_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && divide_fault_reg)
            |-> (value_reg == ALL_ONES && point_mask_reg == POINT_MASK_FREQ))
        else $error("fault word with wrong value or mask");

    a_emit_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit) |=> (state_reg != S_IDLE))
        else $error("result word dropped");

    a_out_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> out_valid_reg)
        else $error("output register not loaded");

endmodule

`default_nettype wire
